[src/rbp_pkg.sv]
// ---------------------------------------------------------------------------
// rbp_pkg
// Shared types and codes of the read-bits response parser.
// ---------------------------------------------------------------------------
package rbp_pkg;

  // result kinds
  localparam logic KindBit    = 1'b0;
  localparam logic KindStatus = 1'b1;

  // frame status codes
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusException = 3'd1;
  localparam logic [2:0] StatusWrongFunc = 3'd2;
  localparam logic [2:0] StatusTooShort  = 3'd3;
  localparam logic [2:0] StatusCountMis  = 3'd4;
  localparam logic [2:0] StatusBadLength = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CfgExpectedFunction = 2'd0;
  localparam logic [1:0] CfgStartAddress     = 2'd1;
  localparam logic [1:0] CfgBitQuantity      = 2'd2;

  localparam logic [7:0] ExceptionFlag = 8'h80;
  localparam int unsigned BitsPerByte  = 8;
  localparam int unsigned QueueDepth   = 4;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;        // data byte to unpack
    logic [3:0]  nbits;       // bit results to emit, 0 to 8
    logic [15:0] addr;        // address of the first bit
    logic        has_status;  // a status result follows the bits
    logic [2:0]  status;
    logic [7:0]  exc;
  } rbp_cmd_t;

endpackage

[src/rbp_front.sv]
// ---------------------------------------------------------------------------
// rbp_front
// Accepts frame bytes, tracks the frame phase and classifies each item into
// an unpack command for the back end.
// ---------------------------------------------------------------------------
module rbp_front #(
  parameter int unsigned MaxQuantity = 2000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_last_i,
  output logic              push_o,
  output rbp_pkg::rbp_cmd_t push_cmd_o,
  input  logic              full_i
);

  localparam logic [2:0] PhFunc  = 3'd0;
  localparam logic [2:0] PhExc   = 3'd1;
  localparam logic [2:0] PhCount = 3'd2;
  localparam logic [2:0] PhData  = 3'd3;
  localparam logic [2:0] PhSkip  = 3'd4;
  localparam logic [10:0] MaxQ   = 11'(MaxQuantity);

  logic [6:0]  exp_func_q;
  logic [15:0] start_addr_q;
  logic [10:0] quantity_q;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  seen_q, seen_d;
  logic [10:0] left_q, left_d;
  logic [15:0] addr_q, addr_d;
  logic [2:0]  err_q, err_d;
  logic [7:0]  exc_q, exc_d;

  logic        accept;
  logic [10:0] clamp_q;
  logic [11:0] round_up;
  logic [8:0]  want;
  logic [3:0]  k;
  logic [3:0]  nbits;
  logic [2:0]  st;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign clamp_q  = (quantity_q > MaxQ) ? MaxQ : quantity_q;
  assign round_up = {1'b0, clamp_q} + 12'd7;
  assign want     = round_up[11:3];
  assign k        = (left_q > 11'(rbp_pkg::BitsPerByte)) ?
                    4'(rbp_pkg::BitsPerByte) : left_q[3:0];

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    seen_d  = seen_q;
    left_d  = left_q;
    addr_d  = addr_q;
    err_d   = err_q;
    exc_d   = exc_q;
    nbits   = 4'd0;
    unique case (phase_q)
      PhExc: begin
        exc_d   = rx_byte_i;
        err_d   = rbp_pkg::StatusException;
        phase_d = PhSkip;
      end
      PhCount: begin
        hdr_d   = rx_byte_i;
        seen_d  = 8'd0;
        left_d  = clamp_q;
        addr_d  = start_addr_q;
        phase_d = PhData;
      end
      PhData: begin
        if (seen_q >= hdr_q) begin
          err_d   = rbp_pkg::StatusCountMis;
          phase_d = PhSkip;
        end else begin
          seen_d = seen_q + 8'd1;
          nbits  = k;
          addr_d = addr_q + 16'(k);
          left_d = left_q - 11'(k);
        end
      end
      PhSkip: begin
      end
      default: begin
        if (rx_byte_i == {1'b0, exp_func_q}) begin
          phase_d = PhCount;
        end else if (rx_byte_i == ({1'b0, exp_func_q} | rbp_pkg::ExceptionFlag)) begin
          phase_d = PhExc;
        end else begin
          err_d   = rbp_pkg::StatusWrongFunc;
          phase_d = PhSkip;
        end
      end
    endcase

    // frame closing status, from the state after this byte
    priority if (phase_d == PhData) begin
      if (seen_d != hdr_d) begin
        st = rbp_pkg::StatusCountMis;
      end else if ({1'b0, hdr_d} != want) begin
        st = rbp_pkg::StatusBadLength;
      end else begin
        st = rbp_pkg::StatusOk;
      end
    end else if (phase_d == PhSkip) begin
      st = err_d;
    end else begin
      st = rbp_pkg::StatusTooShort;
    end
  end

  assign push_o                = accept && (nbits != 4'd0 || frame_last_i);
  assign push_cmd_o.data       = rx_byte_i;
  assign push_cmd_o.nbits      = nbits;
  assign push_cmd_o.addr       = addr_q;
  assign push_cmd_o.has_status = frame_last_i;
  assign push_cmd_o.status     = st;
  assign push_cmd_o.exc        = (st == rbp_pkg::StatusException) ? exc_d : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_func_q   <= 7'd1;
      start_addr_q <= 16'd0;
      quantity_q   <= 11'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rbp_pkg::CfgExpectedFunction: exp_func_q   <= cfg_data_i[6:0];
        rbp_pkg::CfgStartAddress:     start_addr_q <= cfg_data_i;
        rbp_pkg::CfgBitQuantity:      quantity_q   <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFunc;
      hdr_q   <= 8'd0;
      seen_q  <= 8'd0;
      left_q  <= 11'd0;
      addr_q  <= 16'd0;
      err_q   <= 3'd0;
      exc_q   <= 8'd0;
    end else if (accept) begin
      if (frame_last_i) begin
        phase_q <= PhFunc;
        hdr_q   <= 8'd0;
        seen_q  <= 8'd0;
        left_q  <= 11'd0;
        addr_q  <= 16'd0;
        err_q   <= 3'd0;
        exc_q   <= 8'd0;
      end else begin
        phase_q <= phase_d;
        hdr_q   <= hdr_d;
        seen_q  <= seen_d;
        left_q  <= left_d;
        addr_q  <= addr_d;
        err_q   <= err_d;
        exc_q   <= exc_d;
      end
    end
  end

`ifndef SYNTH
  a_seen_le_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (seen_q <= hdr_q))
    else $error("data bytes counted past byte count");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into full queue");
`endif

endmodule

[src/rbp_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// rbp_cmd_fifo
// Short command queue between the front and the back end.
// ---------------------------------------------------------------------------
module rbp_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rbp_pkg::rbp_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rbp_pkg::rbp_cmd_t head_o
);

  localparam int unsigned Depth = rbp_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  rbp_pkg::rbp_cmd_t entry_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count overflow");
`endif

endmodule

[src/rbp_back.sv]
// ---------------------------------------------------------------------------
// rbp_back
// Unpacks queued commands into bit results and the frame status result,
// one result per cycle into the output register while the output is not stalled.
// ---------------------------------------------------------------------------
module rbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rbp_pkg::rbp_cmd_t cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [15:0]       bit_address_o,
  output logic              bit_level_o,
  output logic [2:0]        status_o,
  output logic [7:0]        exception_code_o,
  output logic              last_o
);

  logic        valid_q;
  logic [3:0]  idx_q, idx_d;
  logic        advance;
  logic        is_bit;
  logic        done;
  logic        kind_q;
  logic [15:0] addr_q;
  logic        value_q;
  logic [2:0]  status_q;
  logic [7:0]  exc_q;
  logic        last_q;

  assign advance = cmd_valid_i && (!valid_q || !out_stall_i);
  assign is_bit  = (idx_q < cmd_i.nbits);
  // head is finished after its last bit when no status follows, or after status
  assign done    = is_bit ? ((idx_q + 4'd1 == cmd_i.nbits) && !cmd_i.has_status) : 1'b1;
  assign pop_o   = advance && done;
  assign idx_d   = done ? 4'd0 : idx_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 4'd0;
    end else begin
      if (advance) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (is_bit) begin
        kind_q   <= rbp_pkg::KindBit;
        addr_q   <= cmd_i.addr + 16'(idx_q);
        value_q  <= cmd_i.data[idx_q[2:0]];
        status_q <= rbp_pkg::StatusOk;
        exc_q    <= 8'd0;
        last_q   <= 1'b0;
      end else begin
        kind_q   <= rbp_pkg::KindStatus;
        addr_q   <= 16'd0;
        value_q  <= 1'b0;
        status_q <= cmd_i.status;
        exc_q    <= cmd_i.exc;
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign bit_address_o    = addr_q;
  assign bit_level_o      = value_q;
  assign status_o         = status_q;
  assign exception_code_o = exc_q;
  assign last_o           = last_q;

`ifndef SYNTH
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q <= cmd_i.nbits))
    else $error("unpack index past command bit count");
`endif

endmodule

[src/read_bits_response_parser_unit.sv]
// ---------------------------------------------------------------------------
// read_bits_response_parser_unit
// Streaming parser for read-coils / read-discrete-inputs response frames.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in       in   in_valid_i/in_stall_o rx_byte_i, frame_last_i
//  out      out  out_valid_o/out_stall_i kind, bit_address, bit_level, status,
//                                        exception_code, last
//  cfg      in   cfg_we_i              cfg_index_i, cfg_data_i
//
// A byte is accepted every cycle while the command queue has room.
// Results leave one per cycle from the output register unless out_stall_i holds them,
// so a last data byte of a frame yields up to eight bit results and the status result.
// Reset is asynchronous and clears frame state, queue and output valid.
// The input stalls only when the command queue is full.
// ---------------------------------------------------------------------------
module read_bits_response_parser_unit #(
  parameter int unsigned MaxQuantity = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] bit_address_o,
  output logic        bit_level_o,
  output logic [2:0]  status_o,
  output logic [7:0]  exception_code_o,
  output logic        last_o
);

  logic              push;
  rbp_pkg::rbp_cmd_t push_cmd;
  logic              full;
  logic              pop;
  logic              head_valid;
  rbp_pkg::rbp_cmd_t head;

  rbp_front #(
    .MaxQuantity(MaxQuantity)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .frame_last_i(frame_last_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .full_i      (full)
  );

  rbp_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (head_valid),
    .head_o    (head)
  );

  rbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (head_valid),
    .cmd_i           (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .bit_address_o   (bit_address_o),
    .bit_level_o     (bit_level_o),
    .status_o        (status_o),
    .exception_code_o(exception_code_o),
    .last_o          (last_o)
  );

endmodule

[tb/rbp_frame_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbp_frame_checker
// Watches the byte, result and register ports of the read-bits response
// parser, predicts the results of every accepted byte and compares them,
// field by field and in order, with the results the parser hands out.
// ---------------------------------------------------------------------------
module rbp_frame_checker #(
  parameter int unsigned MaxQuantity = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [15:0] bit_address_i,
  input  logic        bit_level_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  exception_code_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [2:0] {
    AwaitFunc,
    AwaitExc,
    AwaitCount,
    InData,
    Skipping
  } frame_phase_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic        value;
    logic [2:0]  status;
    logic [7:0]  exc;
    logic        last;
  } parse_result_t;

  parse_result_t awaited_results[$];

  // register copies
  logic [6:0]  exp_func;
  logic [15:0] start_addr;
  logic [10:0] quantity;

  // frame state
  frame_phase_e phase;
  logic [7:0]   header_count;
  logic [7:0]   bytes_seen;
  logic [10:0]  bits_left;
  logic [15:0]  next_addr;
  logic [2:0]   err_status;
  logic [7:0]   dev_exc;

  function automatic void clear_frame();
    phase        = AwaitFunc;
    header_count = '0;
    bytes_seen   = '0;
    bits_left    = '0;
    next_addr    = '0;
    err_status   = rbp_pkg::StatusOk;
    dev_exc      = '0;
  endfunction

  function automatic logic [10:0] clamped_quantity();
    return (quantity > MaxQuantity) ? 11'(MaxQuantity) : quantity;
  endfunction

  function automatic void expect_result(logic kind, logic [15:0] addr, logic value,
                                        logic [2:0] st, logic [7:0] exc, logic lst);
    parse_result_t r;
    r.kind   = kind;
    r.addr   = addr;
    r.value  = value;
    r.status = st;
    r.exc    = exc;
    r.last   = lst;
    awaited_results.push_back(r);
  endfunction

  // predictor: one accepted byte in, its results queued
  function automatic void parse_byte(logic [7:0] b, logic fl);
    int         k;
    int         i;
    logic [2:0] st;
    case (phase)
      AwaitExc: begin
        dev_exc    = b;
        err_status = rbp_pkg::StatusException;
        phase      = Skipping;
      end
      AwaitCount: begin
        header_count = b;
        bytes_seen   = '0;
        bits_left    = clamped_quantity();
        next_addr    = start_addr;
        phase        = InData;
      end
      InData: begin
        if (bytes_seen >= header_count) begin
          // excess data byte, rest of the frame is dropped
          err_status = rbp_pkg::StatusCountMis;
          phase      = Skipping;
        end else begin
          k = (bits_left > 11'd8) ? 8 : int'(bits_left);
          bytes_seen++;
          for (i = 0; i < k; i++) begin
            expect_result(rbp_pkg::KindBit, next_addr, b[i], rbp_pkg::StatusOk,
                          8'h00, 1'b0);
            next_addr = next_addr + 16'd1;
          end
          bits_left = bits_left - 11'(k);
        end
      end
      Skipping: begin
      end
      default: begin
        if (b == {1'b0, exp_func}) begin
          phase = AwaitCount;
        end else if (b == ({1'b0, exp_func} | rbp_pkg::ExceptionFlag)) begin
          phase = AwaitExc;
        end else begin
          err_status = rbp_pkg::StatusWrongFunc;
          phase      = Skipping;
        end
      end
    endcase

    if (fl) begin
      if (phase == InData) begin
        if (bytes_seen != header_count) begin
          st = rbp_pkg::StatusCountMis;
        end else if (int'(header_count) != (int'(clamped_quantity()) + 7) / 8) begin
          st = rbp_pkg::StatusBadLength;
        end else begin
          st = rbp_pkg::StatusOk;
        end
      end else if (phase == Skipping) begin
        st = err_status;
      end else begin
        st = rbp_pkg::StatusTooShort;
      end
      expect_result(rbp_pkg::KindStatus, 16'h0000, 1'b0, st,
                    (st == rbp_pkg::StatusException) ? dev_exc : 8'h00, 1'b1);
      clear_frame();
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      exp_func   = 7'd1;
      start_addr = 16'd0;
      quantity   = 11'd1;
      clear_frame();
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rbp_pkg::CfgExpectedFunction: exp_func   = cfg_data_i[6:0];
          rbp_pkg::CfgStartAddress:     start_addr = cfg_data_i;
          rbp_pkg::CfgBitQuantity:      quantity   = cfg_data_i[10:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(rx_byte_i, frame_last_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no expectation waiting: kind %0d addr %0h status %0d",
                 kind_i, bit_address_i, status_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("bit_address", want.addr, bit_address_i);
          check_field("bit_level", want.value, bit_level_i);
          check_field("status", want.status, status_i);
          check_field("exception_code", want.exc, exception_code_i);
          check_field("last", want.last, last_i);
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives response frames into the read-bits response parser: a directed set
// of corner frames, then random frames under changing register settings and
// four idle/stall mixes. A checker beside the parser predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxQuantity  = 2000;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned ModeItems    = 48;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we         = 1'b0;
  logic [1:0]  cfg_index      = rbp_pkg::CfgExpectedFunction;
  logic [15:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte        = '0;
  logic        frame_last     = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        kind;
  logic [15:0] bit_address;
  logic        bit_level;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic        last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct      = 0;

  // register values as last written, for building frames
  logic [6:0]  cur_func = 7'd1;
  logic [10:0] cur_qty  = 11'd1;

  logic [7:0] frame_bytes[$];

  read_bits_response_parser_unit #(
    .MaxQuantity(MaxQuantity)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .frame_last_i    (frame_last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .bit_address_o   (bit_address),
    .bit_level_o     (bit_level),
    .status_o        (status),
    .exception_code_o(exception_code),
    .last_o          (last)
  );

  rbp_frame_checker #(
    .MaxQuantity(MaxQuantity)
  ) u_frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .rx_byte_i       (rx_byte),
    .frame_last_i    (frame_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .bit_address_i   (bit_address),
    .bit_level_i     (bit_level),
    .status_i        (status),
    .exception_code_i(exception_code),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // sends frame_bytes as one frame, last flag on the final byte
  task automatic send_frame();
    logic taken;
    int   i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
      in_valid   <= 1'b1;
      rx_byte    <= frame_bytes[i];
      frame_last <= (i == frame_bytes.size() - 1);
      do begin
        @(negedge clk_i);
        taken = !in_stall;
        @(posedge clk_i);
      end while (!taken);
      items_sent++;
    end
  endtask

  // hold the sender until every awaited result is out, then let the back end settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(logic [6:0] func, logic [15:0] addr, logic [10:0] qty);
    cfg_we    <= 1'b1;
    cfg_index <= rbp_pkg::CfgExpectedFunction;
    cfg_data  <= {9'd0, func};
    @(posedge clk_i);
    cfg_index <= rbp_pkg::CfgStartAddress;
    cfg_data  <= addr;
    @(posedge clk_i);
    cfg_index <= rbp_pkg::CfgBitQuantity;
    cfg_data  <= {5'd0, qty};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_func = func;
    cur_qty  = qty;
  endtask

  task automatic random_config();
    logic [6:0]  func;
    logic [15:0] addr;
    logic [10:0] qty;
    case ($urandom_range(9))
      0:       func = 7'd0;
      1:       func = 7'h7F;
      2, 3, 4: func = 7'd1;
      5, 6:    func = 7'd2;
      default: func = 7'($urandom_range(127));
    endcase
    case ($urandom_range(5))
      0:       addr = 16'h0000;
      1:       addr = 16'hFFFF;
      2:       addr = 16'hFFF0 + 16'($urandom_range(15));
      default: addr = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(11))
      0:       qty = 11'd0;
      1:       qty = 11'(MaxQuantity);
      2:       qty = 11'h7FF;
      3:       qty = 11'($urandom_range(2047));
      default: qty = 11'($urandom_range(1, 40));
    endcase
    set_config(func, addr, qty);
  endtask

  initial begin
    int          mode;
    int unsigned mode_end;
    int          sel;
    int          want;
    int          n;
    int          cnt;
    int          frames;
    logic [7:0]  fc;
    logic [7:0]  b;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: function 1, address 0, one bit
    frame_bytes = '{8'h01, 8'h01, 8'hFF};
    send_frame();
    // frame cut after the function byte
    frame_bytes = '{8'h01};
    send_frame();
    frame_bytes = '{8'h81, 8'hA5};
    send_frame();
    // frame cut before the exception code
    frame_bytes = '{8'h81};
    send_frame();
    // bytes after the exception code are ignored
    frame_bytes = '{8'h81, 8'h03, 8'h55};
    send_frame();
    frame_bytes = '{8'h04, 8'hF0};
    send_frame();

    drain();
    set_config(7'd2, 16'hFFFC, 11'd9);
    // nine bits across the address wrap
    frame_bytes = '{8'h02, 8'h02, 8'hA5, 8'hFF};
    send_frame();
    // more data than the byte count
    frame_bytes = '{8'h02, 8'h01, 8'h11, 8'h22};
    send_frame();
    // count off from the quantity, third byte beyond the quantity
    frame_bytes = '{8'h02, 8'h03, 8'h5A, 8'hC3, 8'h3C};
    send_frame();

    drain();
    set_config(7'h7F, 16'h0000, 11'd0);
    frame_bytes = '{8'h7F, 8'h00};
    send_frame();

    for (mode = 0; mode < 4; mode++) begin
      drain();
      case (mode)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 47; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 47; end
        default: begin sender_idle_pct = 26; stall_pct = 26; end
      endcase
      random_config();
      mode_end = items_sent + ModeItems;
      frames   = 0;
      while (items_sent < mode_end) begin
        if (frames > 0 && $urandom_range(7) == 0) begin
          drain();
          random_config();
        end
        frames++;
        fc   = {1'b0, cur_func};
        want = ((cur_qty > MaxQuantity ? MaxQuantity : int'(cur_qty)) + 7) / 8;
        frame_bytes.delete();
        sel  = $urandom_range(99);
        if (sel < 60) begin
          // well-formed; huge quantities fall back to a short data part
          frame_bytes.push_back(fc);
          frame_bytes.push_back(8'(want));
          n = (want > 6) ? $urandom_range(4) : want;
          repeat (n) frame_bytes.push_back(8'($urandom()));
        end else if (sel < 68) begin
          frame_bytes.push_back(fc | rbp_pkg::ExceptionFlag);
          frame_bytes.push_back(8'($urandom()));
          repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom()));
        end else if (sel < 76) begin
          do b = 8'($urandom()); while (b == fc || b == (fc | rbp_pkg::ExceptionFlag));
          frame_bytes.push_back(b);
          repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom()));
        end else if (sel < 82) begin
          frame_bytes.push_back($urandom_range(1) ? fc : (fc | rbp_pkg::ExceptionFlag));
        end else if (sel < 88) begin
          // excess data bytes for small byte counts, a short data part for large ones
          frame_bytes.push_back(fc);
          frame_bytes.push_back(8'(want));
          n = (want > 6) ? $urandom_range(3) : want + 1 + $urandom_range(2);
          repeat (n) frame_bytes.push_back(8'($urandom()));
        end else if (sel < 94) begin
          // data part short of the byte count
          frame_bytes.push_back(fc);
          frame_bytes.push_back(8'(want));
          n = (want == 0) ? 0 : $urandom_range(want > 4 ? 4 : want - 1);
          repeat (n) frame_bytes.push_back(8'($urandom()));
        end else begin
          // byte count that disagrees with the quantity
          do cnt = $urandom_range(7); while (cnt == want);
          frame_bytes.push_back(fc);
          frame_bytes.push_back(8'(cnt));
          n = $urandom_range(1) ? cnt : $urandom_range(7);
          repeat (n) frame_bytes.push_back(8'($urandom()));
        end
        send_frame();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
src/rbp_pkg.sv
src/rbp_front.sv
src/rbp_cmd_fifo.sv
src/rbp_back.sv
src/read_bits_response_parser_unit.sv
tb/rbp_frame_checker.sv
tb/tb_top.sv
